@@ src/rom_ram_bank_controller_top_macros.svh @@
// ----------------------------------------------------------------------------
// rom_ram_bank_controller_top_macros
// assertion macros shared by the bank controller rtl
// ----------------------------------------------------------------------------
`ifndef ROM_RAM_BANK_CONTROLLER_TOP_MACROS_SVH
`define ROM_RAM_BANK_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define RRBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define RRBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rrbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rrbc_pkg
// types and constants of the rom/ram bank controller
// ----------------------------------------------------------------------------
package rrbc_pkg;

    localparam int SRAM_BYTES    = 32768;
    localparam int ROM_BANK_BITS = 7;
    localparam int SRAM_AW       = $clog2(SRAM_BYTES);

    localparam logic [6:0] ROM_BANK_LIMIT = 7'((1 << ROM_BANK_BITS) - 1);

    localparam logic [1:0] KIND_ROM   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic CFG_ROM_BANK_MASK  = 1'b0;
    localparam logic CFG_RAM_BANK_COUNT = 1'b1;

    localparam logic [1:0] CTL_RAM_ENABLE = 2'd0;
    localparam logic [1:0] CTL_LOW_BANK   = 2'd1;
    localparam logic [1:0] CTL_HIGH_BANK  = 2'd2;
    localparam logic [1:0] CTL_MODE       = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } t_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [20:0] rom_address;
        logic [7:0]  read_data;
    } t_resp;

endpackage

@@ src/rrbc_ram.sv @@
// ----------------------------------------------------------------------------
// rrbc_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module rrbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_en && !i_we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/rom_ram_bank_controller_top.sv @@
// ----------------------------------------------------------------------------
// rom_ram_bank_controller_top
// cartridge bank controller: control registers, rom address translation, sram
// ----------------------------------------------------------------------------
// One request is taken per clock cycle when the response side keeps up; each
// request gives exactly one response after it is accepted. The rate is set by
// the single port of the save sram, which is read or written once per request
// with registered read data. A request stage and an output register
// sit between the two sides, so one more request is taken while a response
// waits. The save sram has no reset: bytes never written read back undefined.
// Control registers change at the accept edge of a control write and the next
// request already sees the new value.
module rom_ram_bank_controller_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [6:0]    i_cfg_data,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  rrbc_pkg::t_req  i_req,
    output logic          o_resp_valid,
    input  logic          i_resp_ready,
    output rrbc_pkg::t_resp o_resp
);

    import rrbc_pkg::*;

    `include "rom_ram_bank_controller_top_macros.svh"

    logic [6:0]  r_rom_mask;
    logic [2:0]  r_ram_cnt;
    logic        r_ram_en;
    logic [4:0]  r_low_bank;
    logic [1:0]  r_high_bank;
    logic        r_adv_mode;

    logic        r_s1_valid;
    logic        r_s1_use_ram;
    t_resp       r_s1_resp;
    logic        r_out_valid;
    t_resp       r_out_resp;

    logic        adv;
    logic        acc;
    logic        in_sram;
    logic        bank0;
    logic [1:0]  ram_bank;
    logic        bank_ok;
    logic [14:0] ram_idx;
    logic        idx_ok;
    logic        ram_en;
    logic        ram_we;
    logic [7:0]  ram_rdata;
    logic [6:0]  rom_bank;
    logic        ctl_write;
    t_resp       n_resp;
    logic        n_use_ram;
    t_resp       n_out_resp;

    assign adv         = !r_out_valid || i_resp_ready;
    assign o_req_ready = !r_s1_valid || adv;
    assign acc         = i_req_valid && o_req_ready;

    // sram bank and index
    assign in_sram  = (i_req.bus_address[15:13] == 3'b101);
    assign bank0    = !r_adv_mode || (r_ram_cnt == 3'd1);
    assign ram_bank = bank0 ? 2'd0 : r_high_bank;
    assign bank_ok  = bank0 || ({1'b0, r_high_bank} < r_ram_cnt);
    assign ram_idx  = {ram_bank, i_req.bus_address[12:0]};
    assign idx_ok   = bank_ok && (32'(ram_idx) < SRAM_BYTES);

    assign ram_en = acc && in_sram && r_ram_en && idx_ok;
    assign ram_we = (i_req.req_type == REQ_WRITE);

    rrbc_ram #(
        .WIDTH (8),
        .DEPTH (SRAM_BYTES)
    ) u_save_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_idx[SRAM_AW-1:0]),
        .i_wdata (i_req.write_byte),
        .o_rdata (ram_rdata)
    );

    assign rom_bank  = {r_high_bank, r_low_bank} & r_rom_mask & ROM_BANK_LIMIT;
    assign ctl_write = acc && (i_req.req_type == REQ_WRITE) && !i_req.bus_address[15];

    // response of the incoming request
    always_comb begin
        n_resp    = '0;
        n_use_ram = 1'b0;
        if (i_req.req_type == REQ_WRITE) begin
            n_resp.result_kind = KIND_WRITE;
        end else if (!i_req.bus_address[15]) begin
            n_resp.result_kind = KIND_ROM;
            if (!i_req.bus_address[14]) begin
                n_resp.rom_address = {5'd0, i_req.bus_address};
            end else begin
                n_resp.rom_address = {rom_bank, i_req.bus_address[13:0]};
            end
        end else if (in_sram) begin
            n_resp.result_kind = KIND_DATA;
            if (!r_ram_en) begin
                n_resp.read_data = 8'hFF;
            end else if (idx_ok) begin
                n_use_ram = 1'b1;
            end
        end else begin
            n_resp.result_kind = KIND_DATA;
            n_resp.read_data   = 8'hFF;
        end
    end

    always_comb begin
        n_out_resp = r_s1_resp;
        if (r_s1_use_ram) begin
            n_out_resp.read_data = ram_rdata;
        end
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_mask  <= 7'd127;
            r_ram_cnt   <= 3'd1;
            r_ram_en    <= 1'b0;
            r_low_bank  <= 5'd1;
            r_high_bank <= 2'd0;
            r_adv_mode  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROM_BANK_MASK:  r_rom_mask <= i_cfg_data;
                    CFG_RAM_BANK_COUNT: r_ram_cnt  <= i_cfg_data[2:0];
                    default:            r_rom_mask <= r_rom_mask;
                endcase
            end
            if (ctl_write) begin
                unique case (i_req.bus_address[14:13])
                    CTL_RAM_ENABLE: r_ram_en <= (i_req.write_byte[3:0] == 4'hA);
                    CTL_LOW_BANK: begin
                        r_low_bank <= (i_req.write_byte[4:0] == 5'd0) ? 5'd1
                                                                     : i_req.write_byte[4:0];
                    end
                    CTL_HIGH_BANK:  r_high_bank <= i_req.write_byte[1:0];
                    CTL_MODE:       r_adv_mode  <= i_req.write_byte[0];
                    default:        r_ram_en    <= r_ram_en;
                endcase
            end
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_resp    <= n_resp;
            r_s1_use_ram <= n_use_ram;
        end
        if (adv && r_s1_valid) begin
            r_out_resp <= n_out_resp;
        end
    end

    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out_resp;

    `RRBC_ASSERT_NOW(a_low_bank_nonzero, 1'b1, r_low_bank != 5'd0, "low bank is zero")
    `RRBC_ASSERT_NOW(a_sram_needs_enable, ram_en, r_ram_en && in_sram, "sram access while disabled")
    `RRBC_ASSERT_NEXT(a_s1_to_out, r_s1_valid && adv, o_resp_valid, "request stage lost")
    `RRBC_ASSERT_NOW(a_stall_full, !o_req_ready, r_s1_valid && r_out_valid, "stall with room")

endmodule

@@ sim/rom_ram_bank_controller_top_tb.sv @@
// ----------------------------------------------------------------------------
// rom_ram_bank_controller_top_tb
// self-checking bench for the cartridge rom/ram bank controller
// ----------------------------------------------------------------------------
// A short table of bus accesses covers reset values, the address extremes,
// the low bank zero fix-up, the enable nibble test, disabled and unmapped
// reads. Phases of random accesses follow, each under its own rom mask and
// sram bank count, with the request side bursting and the response side
// stalling. Each response is checked against a fixed table entry or an
// in-bench model of the banking registers and the save sram.
// ----------------------------------------------------------------------------
module rom_ram_bank_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrbc_pkg::*;

    localparam int N_RANDOM     = 1880;
    localparam int N_PHASES     = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam t_resp RESP_WRITE_DONE = '{KIND_WRITE, 21'd0, 8'h00};
    localparam t_resp RESP_DATA_FF    = '{KIND_DATA, 21'd0, 8'hFF};
    localparam t_resp RESP_FROM_MODEL = '0;

    typedef struct packed {
        t_req  req;
        logic  typed;
        t_resp resp;
    } t_directed_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_index = CFG_ROM_BANK_MASK;
    logic [6:0] i_cfg_data  = '0;
    logic       i_req_valid = 1'b0;
    logic       o_req_ready;
    t_req       i_req       = '0;
    logic       o_resp_valid;
    logic       i_resp_ready = 1'b0;
    t_resp      o_resp;

    rom_ram_bank_controller_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp)
    );

    always #5 i_clk = ~i_clk;

    // bank controller model state
    logic [6:0] rom_mask_q;
    logic [2:0] ram_banks_q;
    logic       ram_en_q;
    logic [4:0] low_bank_q;
    logic [1:0] high_bank_q;
    logic       adv_mode_q;
    logic [7:0] save_ram_q [SRAM_BYTES];
    bit         written_q  [SRAM_BYTES];

    t_resp bus_resp_due [$];
    t_resp due_resp;

    int fail_count   = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    int n_rom_fetch  = 0;
    int n_data_read  = 0;
    int n_write_done = 0;
    int n_settings   = 0;

    int stall_style = 0;
    int stall_left  = 0;

    t_directed_row directed_rows [25] = '{
        '{'{REQ_READ,  16'h0000, 8'h00}, 1'b1, '{KIND_ROM, 21'h000000, 8'h00}},
        '{'{REQ_READ,  16'h3FFF, 8'hFF}, 1'b1, '{KIND_ROM, 21'h003FFF, 8'h00}},
        '{'{REQ_READ,  16'h4000, 8'h00}, 1'b1, '{KIND_ROM, 21'h004000, 8'h00}},
        '{'{REQ_READ,  16'h8000, 8'h00}, 1'b1, RESP_DATA_FF},
        '{'{REQ_READ,  16'hFFFF, 8'hFF}, 1'b1, RESP_DATA_FF},
        '{'{REQ_READ,  16'hA000, 8'h00}, 1'b1, RESP_DATA_FF},
        '{'{REQ_WRITE, 16'hA000, 8'h55}, 1'b1, RESP_WRITE_DONE},
        '{'{REQ_WRITE, 16'h1FFF, 8'hAB}, 1'b1, RESP_WRITE_DONE},
        '{'{REQ_WRITE, 16'h0000, 8'h5A}, 1'b1, RESP_WRITE_DONE},
        '{'{REQ_WRITE, 16'hA000, 8'h00}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_WRITE, 16'hBFFF, 8'hFF}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_READ,  16'hA000, 8'hFF}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_READ,  16'hBFFF, 8'h00}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_WRITE, 16'h2000, 8'h00}, 1'b1, RESP_WRITE_DONE},
        '{'{REQ_READ,  16'h7FFF, 8'h00}, 1'b1, '{KIND_ROM, 21'h007FFF, 8'h00}},
        '{'{REQ_WRITE, 16'h3FFF, 8'hFF}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_WRITE, 16'h4000, 8'hFF}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_READ,  16'h7FFF, 8'h00}, 1'b1, '{KIND_ROM, 21'h1FFFFF, 8'h00}},
        '{'{REQ_READ,  16'h4000, 8'h00}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_WRITE, 16'h6000, 8'h01}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_READ,  16'hBFFF, 8'h00}, 1'b0, RESP_FROM_MODEL},
        '{'{REQ_WRITE, 16'h9FFF, 8'h12}, 1'b1, RESP_WRITE_DONE},
        '{'{REQ_WRITE, 16'hC000, 8'h34}, 1'b1, RESP_WRITE_DONE},
        '{'{REQ_WRITE, 16'h0000, 8'h00}, 1'b1, RESP_WRITE_DONE},
        '{'{REQ_READ,  16'hBFFF, 8'h00}, 1'b1, RESP_DATA_FF}
    };

    function automatic bit in_sram_window(input logic [15:0] addr);
        return addr >= 16'hA000 && addr <= 16'hBFFF;
    endfunction

    function automatic bit sram_slot(input logic [15:0] addr,
                                     output logic [SRAM_AW-1:0] idx);
        logic [1:0] bank;
        bank = 2'd0;
        idx  = '0;
        if (adv_mode_q && ram_banks_q != 3'd1) begin
            if ({1'b0, high_bank_q} >= ram_banks_q) begin
                return 1'b0;
            end
            bank = high_bank_q;
        end
        idx = {bank, addr[12:0]};
        return 32'(idx) < SRAM_BYTES;
    endfunction

    function automatic t_resp bank_ctl_step(input t_req r);
        t_resp              rsp;
        logic [SRAM_AW-1:0] idx;
        logic [6:0]         bank;
        rsp = '0;
        if (r.req_type == REQ_WRITE) begin
            rsp.result_kind = KIND_WRITE;
            if (r.bus_address <= 16'h1FFF) begin
                ram_en_q = (r.write_byte[3:0] == 4'hA);
            end else if (r.bus_address <= 16'h3FFF) begin
                low_bank_q = (r.write_byte[4:0] == 5'd0) ? 5'd1 : r.write_byte[4:0];
            end else if (r.bus_address <= 16'h5FFF) begin
                high_bank_q = r.write_byte[1:0];
            end else if (r.bus_address <= 16'h7FFF) begin
                adv_mode_q = r.write_byte[0];
            end else if (in_sram_window(r.bus_address) && ram_en_q) begin
                if (sram_slot(r.bus_address, idx)) begin
                    save_ram_q[idx] = r.write_byte;
                    written_q[idx]  = 1'b1;
                end
            end
        end else if (r.bus_address <= 16'h3FFF) begin
            rsp.result_kind = KIND_ROM;
            rsp.rom_address = {5'd0, r.bus_address};
        end else if (r.bus_address <= 16'h7FFF) begin
            bank = {high_bank_q, low_bank_q} & rom_mask_q & ROM_BANK_LIMIT;
            rsp.result_kind = KIND_ROM;
            rsp.rom_address = {bank, r.bus_address[13:0]};
        end else if (in_sram_window(r.bus_address)) begin
            rsp.result_kind = KIND_DATA;
            if (!ram_en_q) begin
                rsp.read_data = 8'hFF;
            end else if (sram_slot(r.bus_address, idx)) begin
                rsp.read_data = save_ram_q[idx];
            end else begin
                rsp.read_data = 8'h00;
            end
        end else begin
            rsp.result_kind = KIND_DATA;
            rsp.read_data   = 8'hFF;
        end
        return rsp;
    endfunction

    // a read that would land on a never-written sram byte becomes a write there
    function automatic t_req keep_reads_defined(input t_req r);
        logic [SRAM_AW-1:0] idx;
        if (r.req_type == REQ_READ && in_sram_window(r.bus_address) && ram_en_q) begin
            if (sram_slot(r.bus_address, idx) && !written_q[idx]) begin
                r.req_type = REQ_WRITE;
            end
        end
        return r;
    endfunction

    function automatic t_req random_access();
        t_req        r;
        int unsigned pick;
        logic [12:0] off;
        r.write_byte = 8'($urandom_range(0, 255));
        r.req_type   = REQ_WRITE;
        pick = $urandom_range(0, 99);
        off  = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                           : 13'($urandom_range(0, 31));
        if (pick < 12) begin
            r.bus_address = 16'($urandom_range(16'h0000, 16'h1FFF));
            if ($urandom_range(0, 3) != 0) begin
                r.write_byte[3:0] = 4'hA;
            end
        end else if (pick < 20) begin
            r.bus_address = 16'($urandom_range(16'h2000, 16'h3FFF));
        end else if (pick < 27) begin
            r.bus_address = 16'($urandom_range(16'h4000, 16'h5FFF));
        end else if (pick < 34) begin
            r.bus_address = 16'($urandom_range(16'h6000, 16'h7FFF));
        end else if (pick < 58) begin
            r.bus_address = {3'b101, off};
        end else if (pick < 82) begin
            r.req_type    = REQ_READ;
            r.bus_address = {3'b101, off};
        end else if (pick < 94) begin
            r.req_type    = REQ_READ;
            r.bus_address = 16'($urandom_range(16'h0000, 16'h7FFF));
        end else begin
            r.req_type    = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
            r.bus_address = $urandom_range(0, 1) ? 16'($urandom_range(16'h8000, 16'h9FFF))
                                                 : 16'($urandom_range(16'hC000, 16'hFFFF));
        end
        return r;
    endfunction

    task automatic send_request(input t_req r, input t_resp typed_resp, input logic typed);
        t_resp predicted;
        predicted = bank_ctl_step(r);
        bus_resp_due.push_back(typed ? typed_resp : predicted);
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 24);
        end
    endtask

    task automatic wait_idle();
        while (bus_resp_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_bank_config(input logic [6:0] mask, input logic [2:0] banks);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROM_BANK_MASK;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        i_cfg_index <= CFG_RAM_BANK_COUNT;
        i_cfg_data  <= {4'd0, banks};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rom_mask_q  = mask;
        ram_banks_q = banks;
        n_settings++;
    endtask

    // response side stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 2);
            stall_left  <= $urandom_range(16, 128);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0: i_resp_ready <= 1'b1;
            1: i_resp_ready <= ($urandom_range(0, 3) != 0);
            default: i_resp_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_resp_valid && i_resp_ready) begin
            if (bus_resp_due.size() == 0) begin
                $error("response with none pending: kind %0d rom_address %0h read_data %0h",
                       o_resp.result_kind, o_resp.rom_address, o_resp.read_data);
                fail_count++;
            end else begin
                due_resp = bus_resp_due.pop_front();
                if (o_resp.result_kind !== due_resp.result_kind) begin
                    $error("result_kind: expected %0d, got %0d",
                           due_resp.result_kind, o_resp.result_kind);
                    fail_count++;
                end
                if (o_resp.rom_address !== due_resp.rom_address) begin
                    $error("rom_address: expected %0h, got %0h",
                           due_resp.rom_address, o_resp.rom_address);
                    fail_count++;
                end
                if (o_resp.read_data !== due_resp.read_data) begin
                    $error("read_data: expected %0h, got %0h",
                           due_resp.read_data, o_resp.read_data);
                    fail_count++;
                end
                case (due_resp.result_kind)
                    KIND_ROM:  n_rom_fetch++;
                    KIND_DATA: n_data_read++;
                    default:   n_write_done++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timed out after %0d cycles, %0d responses pending",
                   cycle_count, bus_resp_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [6:0] mask;
        logic [2:0] banks;
        rom_mask_q  = 7'd127;
        ram_banks_q = 3'd1;
        ram_en_q    = 1'b0;
        low_bank_q  = 5'd1;
        high_bank_q = 2'd0;
        adv_mode_q  = 1'b0;
        for (int i = 0; i < SRAM_BYTES; i++) begin
            save_ram_q[i] = 8'h00;
            written_q[i]  = 1'b0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].resp, directed_rows[i].typed);
            pace_sender();
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            i_req_valid <= 1'b0;
            wait_idle();
            case (phase)
                0: begin mask = 7'd127; banks = 3'd4; end
                1: begin mask = 7'd0;   banks = 3'd0; end
                2: begin mask = 7'd127; banks = 3'd1; end
                3: begin mask = 7'h1F;  banks = 3'd2; end
                default: begin
                    mask  = 7'($urandom_range(0, 127));
                    banks = 3'($urandom_range(0, 4));
                end
            endcase
            set_bank_config(mask, banks);
            for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
                send_request(keep_reads_defined(random_access()), RESP_FROM_MODEL, 1'b0);
                pace_sender();
            end
        end

        i_req_valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("bus accesses checked: %0d rom fetches, %0d data reads, %0d writes",
                 n_rom_fetch, n_data_read, n_write_done);
        $display("bank settings exercised: %0d, mismatches: %0d", n_settings, fail_count);
        if (fail_count == 0 && bus_resp_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
